### hdl/tree_path_weight_query_unit_assert.svh
// Assertion macros used by the port-level checker of the tree path weight query unit.
`ifndef TREE_PATH_WEIGHT_QUERY_UNIT_ASSERT_SVH
`define TREE_PATH_WEIGHT_QUERY_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define TPWQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked assertion that is also checked across reset.
`define TPWQ_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/tpwq_pkg.sv
// Types, constants and request formats of the tree path weight query unit.
`default_nettype none

package tpwq_pkg;

  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int DEPTH_W  = 11;
  localparam int SUM_W    = 26;
  localparam int LVL_W    = 5;

  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_LEVELS      = 11;
  localparam int DEF_WEIGHT_BITS = 16;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [DEPTH_W-1:0]  depth_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [LVL_W-1:0]    lvl_t;

  localparam depth_t DEPTH_MAX = '1;
  localparam sum_t   SUM_MAX   = '1;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_LOADED   = 2'd0,
    STATUS_ANSWERED = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    mode_t   mode;
    node_t   node_a;
    node_t   node_b;
    weight_t node_weight;
  } in_data_t;

  typedef struct packed {
    status_t status;
    node_t   meet_node;
    sum_t    path_sum;
  } out_data_t;

  // Per-node record: depth below the sentinel and weight sum from the root.
  typedef struct packed {
    depth_t depth;
    sum_t   sum;
  } nd_rec_t;

  typedef struct packed {
    logic  rd_a_en;
    lvl_t  rd_a_lvl;
    node_t rd_a_node;
    logic  rd_b_en;
    lvl_t  rd_b_lvl;
    node_t rd_b_node;
    logic  wr_en;
    lvl_t  wr_lvl;
    node_t wr_node;
    node_t wr_data;
  } anc_ctl_t;

  typedef struct packed {
    logic    rd_en;
    node_t   rd_node;
    logic    wr_en;
    node_t   wr_node;
    nd_rec_t wr_rec;
  } nd_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_START,
    ST_LD_SUM,
    ST_LD_LIFT,
    ST_Q_RX,
    ST_Q_RY,
    ST_Q_SWAP,
    ST_P1_UP,
    ST_P1_CMP,
    ST_P2_CHK,
    ST_P2_STEP,
    ST_M_RD,
    ST_MP_RD,
    ST_SUM,
    ST_CALC,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

### hdl/tpwq_store.sv
// Ancestor jump memory and node record memory with node-zero masking and forwarding.
`default_nettype none

module tpwq_store #(
  parameter int MAX_NODES = tpwq_pkg::DEF_MAX_NODES,
  parameter int LEVELS    = tpwq_pkg::DEF_LEVELS
) (
  input  wire logic               clk,
  input  wire tpwq_pkg::anc_ctl_t anc_ctl,
  input  wire tpwq_pkg::nd_ctl_t  nd_ctl,
  output tpwq_pkg::node_t         anc_a,
  output tpwq_pkg::node_t         anc_b,
  output tpwq_pkg::nd_rec_t       nd_q
);
  import tpwq_pkg::*;

  localparam int AW        = $clog2(MAX_NODES);
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_DEPTH = LEVELS * (2 ** AW);
  localparam int AAW       = $clog2(ANC_DEPTH);

  function automatic logic [AAW-1:0] anc_addr(input lvl_t lvl, input node_t n);
    return AAW'({lvl[LW-1:0], AW'(n)});
  endfunction

  node_t   anc_mem [ANC_DEPTH];
  nd_rec_t nd_mem  [MAX_NODES];

  logic [AAW-1:0] wr_addr;
  logic [AAW-1:0] rd_a_addr;
  logic [AAW-1:0] rd_b_addr;
  logic [AW-1:0]  nd_rd_addr;
  logic [AW-1:0]  nd_wr_addr;

  node_t   anc_a_raw_r;
  node_t   anc_b_raw_r;
  node_t   fwd_data_r;
  logic    a_zero_r;
  logic    b_zero_r;
  logic    a_fwd_r;
  nd_rec_t nd_raw_r;
  logic    nd_zero_r;

  assign wr_addr    = anc_addr(anc_ctl.wr_lvl, anc_ctl.wr_node);
  assign rd_a_addr  = anc_addr(anc_ctl.rd_a_lvl, anc_ctl.rd_a_node);
  assign rd_b_addr  = anc_addr(anc_ctl.rd_b_lvl, anc_ctl.rd_b_node);
  assign nd_rd_addr = AW'(nd_ctl.rd_node);
  assign nd_wr_addr = AW'(nd_ctl.wr_node);

  always_ff @(posedge clk) begin
    if (anc_ctl.wr_en) begin
      anc_mem[wr_addr] <= anc_ctl.wr_data;
    end
  end

  // Node 0 is never written, so its entries are masked to zero on the way out.
  // Port A also sees a write to the same entry in the same cycle.
  always_ff @(posedge clk) begin
    if (anc_ctl.rd_a_en) begin
      anc_a_raw_r <= anc_mem[rd_a_addr];
      a_zero_r    <= (anc_ctl.rd_a_node == '0);
      a_fwd_r     <= anc_ctl.wr_en && (wr_addr == rd_a_addr);
      fwd_data_r  <= anc_ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (anc_ctl.rd_b_en) begin
      anc_b_raw_r <= anc_mem[rd_b_addr];
      b_zero_r    <= (anc_ctl.rd_b_node == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (nd_ctl.wr_en) begin
      nd_mem[nd_wr_addr] <= nd_ctl.wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (nd_ctl.rd_en) begin
      nd_raw_r  <= nd_mem[nd_rd_addr];
      nd_zero_r <= (nd_ctl.rd_node == '0);
    end
  end

  assign anc_a = a_zero_r ? node_t'('0) : (a_fwd_r ? fwd_data_r : anc_a_raw_r);
  assign anc_b = b_zero_r ? node_t'('0) : anc_b_raw_r;
  assign nd_q  = nd_zero_r ? nd_rec_t'('0) : nd_raw_r;

endmodule

`default_nettype wire

### hdl/tree_path_weight_query_unit.sv
// Tree path weight query unit: keeps a rooted, vertex-weighted tree as binary-lifting tables
// and answers lowest-common-ancestor and path-weight requests. A load request names a node,
// its parent (0 for a root) and its weight; parents must be loaded before their children.
// Loading node 0, or a node or parent at or above MAX_NODES, is rejected with no change.
// A query request names two loaded nodes and returns their meeting node and the weight sum
// of the path between them, both ends included. One request is in the block at a time, and
// each gives exactly one result; a new request is taken while the previous result still
// waits at the output register. A load passes through a start state, a sum state and one
// lift state per level above the first; a rejected load goes straight to the response.
// A query whose one node is the ancestor of the other skips the joint climb; a stalled
// result delays the next one. The query time is set by the registered reads of the
// ancestor memory: the depth-matching climb needs an ancestor read and a node record read
// per level, and the joint climb one read per level.
// The memories need no clearing after reset, since node 0 reads as zero by construction.
`default_nettype none

module tree_path_weight_query_unit #(
  parameter int MAX_NODES   = tpwq_pkg::DEF_MAX_NODES,
  parameter int LEVELS      = tpwq_pkg::DEF_LEVELS,
  parameter int WEIGHT_BITS = tpwq_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tpwq_pkg::in_data_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tpwq_pkg::out_data_t     out_data
);
  import tpwq_pkg::*;

  localparam lvl_t LVL_LAST = lvl_t'(LEVELS - 1);
  localparam weight_t WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}} :
                                    WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  function automatic logic node_in_range(input node_t n);
    return 32'(n) < 32'(MAX_NODES);
  endfunction

  state_t    state_r, state_nxt;
  node_t     x_r, x_nxt;
  node_t     y_r, y_nxt;
  depth_t    dx_r, dx_nxt;
  depth_t    dy_r, dy_nxt;
  weight_t   w_r, w_nxt;
  lvl_t      lvl_r, lvl_nxt;
  logic [SUM_W:0] plus_r, plus_nxt;
  logic [SUM_W:0] minus_r, minus_nxt;
  status_t   status_r, status_nxt;
  node_t     meet_r, meet_nxt;
  sum_t      psum_r, psum_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_data_t out_data_r, out_data_nxt;

  anc_ctl_t  anc_ctl;
  nd_ctl_t   nd_ctl;
  node_t     anc_a;
  node_t     anc_b;
  nd_rec_t   nd_q;

  logic [SUM_W:0] ld_sum;
  logic [SUM_W:0] q_diff;
  node_t     p1_x;
  node_t     p2_x;
  node_t     p2_y;

  tpwq_store #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_store (
    .clk     (clk),
    .anc_ctl (anc_ctl),
    .nd_ctl  (nd_ctl),
    .anc_a   (anc_a),
    .anc_b   (anc_b),
    .nd_q    (nd_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ld_sum = {1'b0, nd_q.sum} + (SUM_W + 1)'(w_r);
  assign q_diff = plus_r - minus_r;
  // Climb to the ancestor only if it is still no shallower than the other node.
  assign p1_x   = (nd_q.depth >= dy_r) ? anc_a : x_r;
  assign p2_x   = (anc_a != anc_b) ? anc_a : x_r;
  assign p2_y   = (anc_a != anc_b) ? anc_b : y_r;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    w_nxt         = w_r;
    lvl_nxt       = lvl_r;
    plus_nxt      = plus_r;
    minus_nxt     = minus_r;
    status_nxt    = status_r;
    meet_nxt      = meet_r;
    psum_nxt      = psum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    anc_ctl       = '0;
    nd_ctl        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          meet_nxt = '0;
          psum_nxt = '0;
          if (in_data.mode == MODE_LOAD) begin
            x_nxt = in_data.node_a;
            y_nxt = in_data.node_b;
            w_nxt = in_data.node_weight & WEIGHT_MASK;
            if (in_data.node_a == '0 || !node_in_range(in_data.node_a) ||
                !node_in_range(in_data.node_b)) begin
              status_nxt = STATUS_REJECTED;
              state_nxt  = ST_RESP;
            end else begin
              status_nxt = STATUS_LOADED;
              state_nxt  = ST_LD_START;
            end
          end else begin
            x_nxt      = node_in_range(in_data.node_a) ? in_data.node_a : node_t'('0);
            y_nxt      = node_in_range(in_data.node_b) ? in_data.node_b : node_t'('0);
            status_nxt = STATUS_ANSWERED;
            state_nxt  = ST_Q_RX;
          end
        end
      end

      ST_LD_START: begin
        nd_ctl.rd_en      = 1'b1;
        nd_ctl.rd_node    = y_r;
        anc_ctl.wr_en     = 1'b1;
        anc_ctl.wr_lvl    = '0;
        anc_ctl.wr_node   = x_r;
        anc_ctl.wr_data   = y_r;
        anc_ctl.rd_a_en   = 1'b1;
        anc_ctl.rd_a_lvl  = '0;
        anc_ctl.rd_a_node = y_r;
        state_nxt         = ST_LD_SUM;
      end

      ST_LD_SUM: begin
        nd_ctl.wr_en        = 1'b1;
        nd_ctl.wr_node      = x_r;
        nd_ctl.wr_rec.depth = (nd_q.depth == DEPTH_MAX) ? DEPTH_MAX :
                              depth_t'(nd_q.depth + 1'b1);
        nd_ctl.wr_rec.sum   = ld_sum[SUM_W] ? SUM_MAX : ld_sum[SUM_W-1:0];
        lvl_nxt             = lvl_t'(1);
        if (LEVELS == 1) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_LD_LIFT;
        end
      end

      // The jump just read is this level's entry of the new node, and its own
      // entry at the same level is the next jump up.
      ST_LD_LIFT: begin
        anc_ctl.wr_en     = 1'b1;
        anc_ctl.wr_lvl    = lvl_r;
        anc_ctl.wr_node   = x_r;
        anc_ctl.wr_data   = anc_a;
        anc_ctl.rd_a_en   = (lvl_r != LVL_LAST);
        anc_ctl.rd_a_lvl  = lvl_r;
        anc_ctl.rd_a_node = anc_a;
        if (lvl_r == LVL_LAST) begin
          state_nxt = ST_RESP;
        end else begin
          lvl_nxt = lvl_t'(lvl_r + 1'b1);
        end
      end

      ST_Q_RX: begin
        nd_ctl.rd_en   = 1'b1;
        nd_ctl.rd_node = x_r;
        state_nxt      = ST_Q_RY;
      end

      ST_Q_RY: begin
        dx_nxt         = nd_q.depth;
        plus_nxt       = {1'b0, nd_q.sum};
        nd_ctl.rd_en   = 1'b1;
        nd_ctl.rd_node = y_r;
        state_nxt      = ST_Q_SWAP;
      end

      ST_Q_SWAP: begin
        plus_nxt = plus_r + {1'b0, nd_q.sum};
        if (dx_r < nd_q.depth) begin
          x_nxt  = y_r;
          y_nxt  = x_r;
          dy_nxt = dx_r;
        end else begin
          dy_nxt = nd_q.depth;
        end
        anc_ctl.rd_a_en   = 1'b1;
        anc_ctl.rd_a_lvl  = LVL_LAST;
        anc_ctl.rd_a_node = x_nxt;
        lvl_nxt           = LVL_LAST;
        state_nxt         = ST_P1_UP;
      end

      ST_P1_UP: begin
        nd_ctl.rd_en   = 1'b1;
        nd_ctl.rd_node = anc_a;
        state_nxt      = ST_P1_CMP;
      end

      ST_P1_CMP: begin
        x_nxt = p1_x;
        if (lvl_r == '0) begin
          state_nxt = ST_P2_CHK;
        end else begin
          lvl_nxt           = lvl_t'(lvl_r - 1'b1);
          anc_ctl.rd_a_en   = 1'b1;
          anc_ctl.rd_a_lvl  = lvl_t'(lvl_r - 1'b1);
          anc_ctl.rd_a_node = p1_x;
          state_nxt         = ST_P1_UP;
        end
      end

      ST_P2_CHK: begin
        if (x_r == y_r) begin
          meet_nxt          = x_r;
          anc_ctl.rd_a_en   = 1'b1;
          anc_ctl.rd_a_lvl  = '0;
          anc_ctl.rd_a_node = x_r;
          nd_ctl.rd_en      = 1'b1;
          nd_ctl.rd_node    = x_r;
          state_nxt         = ST_MP_RD;
        end else begin
          anc_ctl.rd_a_en   = 1'b1;
          anc_ctl.rd_a_lvl  = LVL_LAST;
          anc_ctl.rd_a_node = x_r;
          anc_ctl.rd_b_en   = 1'b1;
          anc_ctl.rd_b_lvl  = LVL_LAST;
          anc_ctl.rd_b_node = y_r;
          lvl_nxt           = LVL_LAST;
          state_nxt         = ST_P2_STEP;
        end
      end

      ST_P2_STEP: begin
        x_nxt = p2_x;
        y_nxt = p2_y;
        if (lvl_r == '0) begin
          anc_ctl.rd_a_en   = 1'b1;
          anc_ctl.rd_a_lvl  = '0;
          anc_ctl.rd_a_node = p2_x;
          state_nxt         = ST_M_RD;
        end else begin
          lvl_nxt           = lvl_t'(lvl_r - 1'b1);
          anc_ctl.rd_a_en   = 1'b1;
          anc_ctl.rd_a_lvl  = lvl_t'(lvl_r - 1'b1);
          anc_ctl.rd_a_node = p2_x;
          anc_ctl.rd_b_en   = 1'b1;
          anc_ctl.rd_b_lvl  = lvl_t'(lvl_r - 1'b1);
          anc_ctl.rd_b_node = p2_y;
        end
      end

      ST_M_RD: begin
        meet_nxt          = anc_a;
        anc_ctl.rd_a_en   = 1'b1;
        anc_ctl.rd_a_lvl  = '0;
        anc_ctl.rd_a_node = anc_a;
        nd_ctl.rd_en      = 1'b1;
        nd_ctl.rd_node    = anc_a;
        state_nxt         = ST_MP_RD;
      end

      // The meeting node's parent is counted out together with the meeting node.
      ST_MP_RD: begin
        minus_nxt      = {1'b0, nd_q.sum};
        nd_ctl.rd_en   = 1'b1;
        nd_ctl.rd_node = anc_a;
        state_nxt      = ST_SUM;
      end

      ST_SUM: begin
        minus_nxt = minus_r + {1'b0, nd_q.sum};
        state_nxt = ST_CALC;
      end

      ST_CALC: begin
        if (plus_r >= minus_r) begin
          psum_nxt = q_diff[SUM_W] ? SUM_MAX : q_diff[SUM_W-1:0];
        end else begin
          psum_nxt = '0;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = status_r;
          out_data_nxt.meet_node = meet_r;
          out_data_nxt.path_sum  = psum_r;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    w_r        <= w_nxt;
    lvl_r      <= lvl_nxt;
    plus_r     <= plus_nxt;
    minus_r    <= minus_nxt;
    status_r   <= status_nxt;
    meet_r     <= meet_nxt;
    psum_r     <= psum_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### hdl/tpwq_checker.sv
// Port-level assertion checker of the tree path weight query unit and its bind.
`default_nettype none
`include "tree_path_weight_query_unit_assert.svh"

module tpwq_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tpwq_pkg::out_data_t out_data
);
  import tpwq_pkg::*;

  // The block works on one request at a time.
  `TPWQ_ASSERT(a_one_request, in_valid && !in_stall |=> in_stall, "request accepted while another is in work")
  // Loads and rejected loads carry no meeting node and no path sum.
  `TPWQ_ASSERT(a_load_zero, out_valid && out_data.status != STATUS_ANSWERED |-> out_data.meet_node == '0 && out_data.path_sum == '0, "non-query result with nonzero payload")
  `TPWQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed or dropped")
  `TPWQ_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind tree_path_weight_query_unit tpwq_checker u_tpwq_checker (.*);

`default_nettype wire

### bench/tree_path_weight_query_unit_tb.sv
// Self-checking testbench for the tree path weight query unit.
module tree_path_weight_query_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpwq_pkg::*;

  localparam int NODES           = DEF_MAX_NODES;
  localparam int LEVELS          = DEF_LEVELS;
  localparam int RANDOM_REQUESTS = 300;
  localparam int SELF_RELOADS    = 40;
  localparam int DRAIN_CYCLES    = 60;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PRINT_LIMIT     = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_data_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_data_t out_data;

  // Shadow copy of the lifting tables, depths and root sums.
  node_t  anc_tab     [LEVELS][NODES];
  depth_t depth_of    [NODES];
  sum_t   root_sum_of [NODES];
  bit     is_loaded   [NODES];
  node_t  live_nodes  [$];
  node_t  last_loaded = '0;

  out_data_t pending_replies [$];

  int mismatches   = 0;
  int loads_done   = 0;
  int rejects_done = 0;
  int queries_done = 0;
  int cycle_count  = 0;
  bit steady       = 1'b0;

  tree_path_weight_query_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d replies outstanding.",
               cycle_count, pending_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 22);
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  function automatic node_t meet_node_of(node_t a, node_t b);
    node_t x;
    node_t y;
    node_t ux;
    node_t uy;
    x = a;
    y = b;
    if (depth_of[x] < depth_of[y]) begin
      x = b;
      y = a;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (depth_of[anc_tab[i][x]] >= depth_of[y]) begin
        x = anc_tab[i][x];
      end
    end
    if (x == y) begin
      return x;
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      ux = anc_tab[i][x];
      uy = anc_tab[i][y];
      if (ux != uy) begin
        x = ux;
        y = uy;
      end
    end
    return anc_tab[0][x];
  endfunction

  // Applies one request to the shadow tree and returns the reply it must give.
  function automatic out_data_t tree_step(in_data_t req);
    out_data_t        reply;
    node_t            u;
    node_t            p;
    node_t            m;
    node_t            mp;
    logic [DEPTH_W:0] d;
    logic [SUM_W:0]   s;
    logic [SUM_W+1:0] plus;
    logic [SUM_W+1:0] minus;
    logic [SUM_W+1:0] diff;
    reply = '0;
    u = req.node_a;
    p = req.node_b;
    if (req.mode == MODE_LOAD) begin
      if (u == '0) begin
        reply.status = STATUS_REJECTED;
        return reply;
      end
      d = depth_of[p] + 1'b1;
      if (d > DEPTH_MAX) d = DEPTH_MAX;
      s = root_sum_of[p] + req.node_weight;
      if (s > SUM_MAX) s = SUM_MAX;
      depth_of[u]    = d[DEPTH_W-1:0];
      root_sum_of[u] = s[SUM_W-1:0];
      anc_tab[0][u]  = p;
      // Level i reuses level i-1, which may already point back at this node.
      for (int i = 1; i < LEVELS; i++) begin
        anc_tab[i][u] = anc_tab[i-1][anc_tab[i-1][u]];
      end
      if (!is_loaded[u]) begin
        is_loaded[u] = 1'b1;
        live_nodes.push_back(u);
      end
      last_loaded  = u;
      reply.status = STATUS_LOADED;
    end else begin
      m     = meet_node_of(u, p);
      mp    = anc_tab[0][m];
      plus  = root_sum_of[u] + root_sum_of[p];
      minus = root_sum_of[m] + root_sum_of[mp];
      diff  = (plus >= minus) ? plus - minus : '0;
      if (diff > SUM_MAX) diff = SUM_MAX;
      reply.status    = STATUS_ANSWERED;
      reply.meet_node = m;
      reply.path_sum  = diff[SUM_W-1:0];
    end
    return reply;
  endfunction

  function automatic node_t random_live();
    return live_nodes[$urandom_range(live_nodes.size() - 1)];
  endfunction

  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %p arrived with no request outstanding", out_data));
      end else begin
        want = pending_replies.pop_front();
        if (out_data.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
        end
        if (out_data.meet_node !== want.meet_node) begin
          report_mismatch($sformatf("meet_node %0d, expected %0d",
                                    out_data.meet_node, want.meet_node));
        end
        if (out_data.path_sum !== want.path_sum) begin
          report_mismatch($sformatf("path_sum %0d, expected %0d",
                                    out_data.path_sum, want.path_sum));
        end
      end
    end
  end

  // Holds the request until it is taken, then records the reply it must give.
  task automatic send_request(in_data_t req);
    while (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(tree_step(req));
    if (req.mode == MODE_QUERY) queries_done++;
    else if (req.node_a == '0) rejects_done++;
    else loads_done++;
  endtask

  task automatic load_node(node_t u, node_t p, weight_t w);
    in_data_t req;
    req.mode        = MODE_LOAD;
    req.node_a      = u;
    req.node_b      = p;
    req.node_weight = w;
    send_request(req);
  endtask

  task automatic query_pair(node_t a, node_t b);
    in_data_t req;
    req.mode        = MODE_QUERY;
    req.node_a      = a;
    req.node_b      = b;
    req.node_weight = weight_t'($urandom);
    send_request(req);
  endtask

  task automatic test_directed();
    query_pair('0, '0);
    load_node('0, 10'h3FF, 16'hFFFF);
    load_node(10'h001, '0, 16'hFFFF);
    load_node(10'h3FF, 10'h001, 16'h0000);
    load_node(10'h002, 10'h001, 16'h0001);
    load_node(10'h2AA, 10'h002, 16'h5555);
    load_node(10'h155, 10'h2AA, 16'hAAAA);
    load_node(10'h200, '0, 16'd300);
    query_pair(10'h3FF, 10'h155);
    query_pair(10'h155, 10'h002);
    query_pair(10'h002, 10'h155);
    query_pair(10'h001, 10'h001);
    query_pair(10'h3FF, 10'h200);
    query_pair('0, 10'h002);
    load_node('0, '0, '0);
    // Hanging the root below one of its own descendants leaves stale sums below it.
    load_node(10'h001, 10'h155, 16'hFFFF);
    query_pair(10'h3FF, 10'h3FF);
    query_pair(10'h3FF, 10'h155);
    query_pair(10'h001, 10'h2AA);
    load_node(10'h002, 10'h002, 16'h8000);
    query_pair(10'h002, 10'h155);
    query_pair(10'h200, 10'h200);
  endtask

  task automatic test_random_forest();
    in_data_t req;
    node_t    cand;
    node_t    other;
    bit       found;
    int       pick;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 100 && n < 250);
      pick = $urandom_range(99);
      req.node_weight = weight_t'($urandom);
      if (pick < 4) begin
        req.mode   = MODE_LOAD;
        req.node_a = '0;
        req.node_b = node_t'($urandom);
      end else if (pick < 40) begin
        req.mode = MODE_LOAD;
        found = 1'b0;
        cand = '0;
        if ($urandom_range(9) < 8) begin
          for (int t = 0; t < 16 && !found; t++) begin
            cand  = node_t'($urandom_range(NODES - 1, 1));
            found = !is_loaded[cand];
          end
        end
        req.node_a = found ? cand : random_live();
        // Parents are always loaded nodes or the sentinel; chains grow from the last load.
        case ($urandom_range(9))
          0, 1:    req.node_b = '0;
          2, 3, 4: req.node_b = last_loaded;
          default: req.node_b = random_live();
        endcase
        case ($urandom_range(3))
          0:       req.node_weight = '0;
          1:       req.node_weight = '1;
          default: ;
        endcase
      end else begin
        req.mode   = MODE_QUERY;
        req.node_a = random_live();
        case ($urandom_range(9))
          0:       req.node_b = req.node_a;
          1, 2:    req.node_b = anc_tab[$urandom_range(LEVELS - 1)][req.node_a];
          3:       req.node_b = '0;
          default: req.node_b = random_live();
        endcase
        if ($urandom_range(1) == 1) begin
          other      = req.node_a;
          req.node_a = req.node_b;
          req.node_b = other;
        end
      end
      send_request(req);
    end
    steady = 1'b0;
  endtask

  task automatic test_deep_chain();
    load_node(10'h001, '0, '1);
    for (int k = 2; k < NODES; k++) begin
      load_node(node_t'(k), node_t'(k - 1), '1);
      if (k % 128 == 0) query_pair(node_t'(k), node_t'($urandom_range(k, 1)));
    end
    query_pair(10'h3FF, 10'h001);
    // As its own parent, the deepest node gains one level per reload; its root sum
    // saturates after the first two.
    for (int r = 0; r < SELF_RELOADS; r++) begin
      load_node(10'h3FF, 10'h3FF, '1);
      if (r % 10 == 0) query_pair(10'h3FF, random_live());
    end
    load_node(10'h005, 10'h3FF, '0);
    load_node(10'h006, 10'h3FF, 16'd12345);
    // Re-rooting the shared parent leaves both children with saturated sums, so their path
    // sum saturates.
    load_node(10'h3FF, '0, '0);
    query_pair(10'h005, 10'h006);
    query_pair(10'h005, 10'h005);
    query_pair(10'h006, 10'h3FF);
    query_pair(10'h005, 10'h001);
  endtask

  initial begin
    for (int n = 0; n < NODES; n++) begin
      depth_of[n]    = '0;
      root_sum_of[n] = '0;
      is_loaded[n]   = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        anc_tab[i][n] = '0;
      end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_forest();
    test_deep_chain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d node loads, %0d rejected loads and %0d path queries,",
             loads_done, rejects_done, queries_done);
    $display("over random forests and a full-depth chain driven into root sum saturation.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
